>>> design/smse_pkg.sv
// ----------------------------------------------------------------------------
// smse_pkg
// shared constants for the sorted marker set engine
// ----------------------------------------------------------------------------
package smse_pkg;

    localparam int MAX_ENTRIES_DEF = 32;

    localparam int POS_W   = 31;
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 8;
    localparam int STAT_W  = 2;
    localparam int FIDX_W  = 5;
    localparam int CNT_W   = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

>>> design/smse_cmd_if.sv
// ----------------------------------------------------------------------------
// smse_cmd_if
// command channel: one command item per handshake
// ----------------------------------------------------------------------------
interface smse_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [smse_pkg::CMD_W-1:0]          cmd;
    logic signed [smse_pkg::POS_W:0]     position;
    logic [smse_pkg::IDX_W-1:0]          entry_index;
    logic [smse_pkg::POS_W-1:0]          tolerance;

    modport source (output valid, cmd, position, entry_index, tolerance, input ready);
    modport sink   (input valid, cmd, position, entry_index, tolerance, output ready);
endinterface

>>> design/smse_res_if.sv
// ----------------------------------------------------------------------------
// smse_res_if
// result channel: one result item per handshake
// ----------------------------------------------------------------------------
interface smse_res_if;
    logic                          valid;
    logic                          ready;
    logic [smse_pkg::STAT_W-1:0]   status;
    logic [smse_pkg::FIDX_W-1:0]   found_index;
    logic [smse_pkg::POS_W-1:0]    region_start;
    logic [smse_pkg::POS_W-1:0]    region_end;
    logic [smse_pkg::CNT_W-1:0]    entry_count;
    logic                          last;

    modport source (output valid, status, found_index, region_start, region_end,
                    entry_count, last, input ready);
    modport sink   (input valid, status, found_index, region_start, region_end,
                    entry_count, last, output ready);
endinterface

>>> design/smse_cfg_if.sv
// ----------------------------------------------------------------------------
// smse_cfg_if
// configuration write channel for the clip length register
// ----------------------------------------------------------------------------
interface smse_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [smse_pkg::POS_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> design/sorted_marker_set_engine_unit.sv
// ----------------------------------------------------------------------------
// sorted_marker_set_engine_unit
// sorted, duplicate-free set of cut positions with nearest search and listing
// ----------------------------------------------------------------------------
// channels: i_cmd takes one command item, o_res returns its result items,
//   i_cfg writes clip_length (always ready, write only while idle)
// a command is taken only while the sequencer is idle; every command gives
//   one result item with last set, list gives entry_count+1 items
// the sequencer walks the position memory entry by entry: read, then
//   evaluate or write back; list gives one result item per entry walked
// the next command can be taken while the last result item of the previous
//   one is still presented, but not before that last item is registered
// reset: entry count and clip length clear at once, no memory sweep
// a stalled receiver holds the result register; a list walk waits on it,
//   other commands finish and wait in the response step
// ----------------------------------------------------------------------------
module sorted_marker_set_engine_unit #(
    parameter int MAX_ENTRIES = smse_pkg::MAX_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smse_cmd_if.sink    i_cmd,
    smse_res_if.source  o_res,
    smse_cfg_if.sink    i_cfg
);
    localparam int AW = $clog2(MAX_ENTRIES);

    logic                       re;
    logic [AW-1:0]              raddr;
    logic [smse_pkg::POS_W-1:0] rdata;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [smse_pkg::POS_W-1:0] wdata;

    smse_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .i_cfg   (i_cfg),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata)
    );

    smse_store #(
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata)
    );
endmodule

>>> design/smse_store.sv
// ----------------------------------------------------------------------------
// smse_store
// position memory, one write and one registered read port
// ----------------------------------------------------------------------------
module smse_store #(
    parameter int DEPTH = smse_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [smse_pkg::POS_W-1:0] o_rdata,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [smse_pkg::POS_W-1:0] i_wdata
);
    logic [smse_pkg::POS_W-1:0] r_mem [DEPTH];
    logic [smse_pkg::POS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/smse_ctrl.sv
// ----------------------------------------------------------------------------
// smse_ctrl
// command sequencer: walks the position memory, shifts, scans and lists
// ----------------------------------------------------------------------------
module smse_ctrl #(
    parameter int MAX_ENTRIES = smse_pkg::MAX_ENTRIES_DEF,
    parameter int AW          = $clog2(MAX_ENTRIES),
    parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    smse_cmd_if.sink                   i_cmd,
    smse_res_if.source                 o_res,
    smse_cfg_if.sink                   i_cfg,
    output logic                       o_re,
    output logic [AW-1:0]              o_raddr,
    input  logic [smse_pkg::POS_W-1:0] i_rdata,
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output logic [smse_pkg::POS_W-1:0] o_wdata
);
    localparam int PW = smse_pkg::POS_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PRUNE = 8'b0000_0010,
        S_ISCAN = 8'b0000_0100,
        S_SHUP  = 8'b0000_1000,
        S_SHDN  = 8'b0001_0000,
        S_FIND  = 8'b0010_0000,
        S_LIST  = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state r_st, n_st;
    logic [smse_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [PW-1:0]               r_np, n_np;
    logic                        r_ok, n_ok;
    logic signed [PW:0]          r_pos, n_pos;
    logic [PW-1:0]               r_tol, n_tol;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [CW-1:0]               r_i, n_i;
    logic [CW-1:0]               r_j, n_j;
    logic                        r_wait, n_wait;
    logic [PW-1:0]               r_clip;
    logic [PW+1:0]               r_bestd, n_bestd;
    logic [AW-1:0]               r_best, n_best;
    logic                        r_fnd, n_fnd;
    logic [PW-1:0]               r_prev, n_prev;
    logic [smse_pkg::STAT_W-1:0] r_status, n_status;
    logic [AW-1:0]               r_fidx, n_fidx;

    logic                        r_ov, n_ov;
    logic [smse_pkg::STAT_W-1:0] r_o_status, n_o_status;
    logic [smse_pkg::FIDX_W-1:0] r_o_fidx, n_o_fidx;
    logic [PW-1:0]               r_o_rs, n_o_rs;
    logic [PW-1:0]               r_o_re, n_o_re;
    logic [smse_pkg::CNT_W-1:0]  r_o_cnt, n_o_cnt;
    logic                        r_o_last, n_o_last;

    logic                        out_free;
    logic [PW-1:0]               hi;
    logic signed [PW+2:0]        diff;
    logic [PW+1:0]               gap_abs;

    assign out_free = !r_ov || o_res.ready;
    assign hi       = (r_clip > PW'(2)) ? (r_clip - PW'(1)) : PW'(1);
    assign diff     = $signed({3'b000, i_rdata}) - (PW+3)'(r_pos);
    assign gap_abs  = diff[PW+2] ? (PW+2)'(-diff) : diff[PW+1:0];

    assign i_cmd.ready = (r_st == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_np = r_np; n_ok = r_ok; n_pos = r_pos;
        n_tol = r_tol; n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_wait = r_wait;
        n_bestd = r_bestd; n_best = r_best; n_fnd = r_fnd; n_prev = r_prev;
        n_status = r_status; n_fidx = r_fidx;
        n_ov = r_ov && !o_res.ready;
        n_o_status = r_o_status; n_o_fidx = r_o_fidx; n_o_rs = r_o_rs;
        n_o_re = r_o_re; n_o_cnt = r_o_cnt; n_o_last = r_o_last;
        o_re = 1'b0; o_raddr = '0; o_we = 1'b0; o_waddr = '0; o_wdata = '0;

        case (r_st)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd    = i_cmd.cmd;
                    n_pos    = i_cmd.position;
                    n_tol    = i_cmd.tolerance;
                    n_i      = '0;
                    n_wait   = 1'b0;
                    n_status = smse_pkg::ST_OK;
                    n_fidx   = '0;
                    case (i_cmd.cmd)
                        smse_pkg::CMD_INSERT: begin
                            n_np = i_cmd.position[PW-1:0];
                            n_ok = !i_cmd.position[PW] && (i_cmd.position != '0)
                                   && (i_cmd.position[PW-1:0] < r_clip);
                            n_st = S_PRUNE;
                        end
                        smse_pkg::CMD_REMOVE, smse_pkg::CMD_MOVE: begin
                            if (i_cmd.position[PW] || i_cmd.position == '0) begin
                                n_np = PW'(1);
                            end else if (i_cmd.position[PW-1:0] > hi) begin
                                n_np = hi;
                            end else begin
                                n_np = i_cmd.position[PW-1:0];
                            end
                            n_ok = 1'b0;
                            if ({1'b0, i_cmd.entry_index} >= 9'(r_cnt)) begin
                                n_status = smse_pkg::ST_MISS;
                                n_st     = S_RESP;
                            end else begin
                                n_j  = CW'(i_cmd.entry_index);
                                n_st = S_SHDN;
                            end
                        end
                        smse_pkg::CMD_FIND: begin
                            n_bestd = {2'b00, i_cmd.tolerance} + (PW+2)'(1);
                            n_fnd   = 1'b0;
                            n_best  = '0;
                            n_st    = S_FIND;
                        end
                        smse_pkg::CMD_CLEAR: begin
                            n_cnt = '0;
                            n_st  = S_RESP;
                        end
                        smse_pkg::CMD_LIST: begin
                            n_prev = '0;
                            if (r_cnt == '0) begin
                                n_status = smse_pkg::ST_MISS;
                                n_st     = S_RESP;
                            end else begin
                                n_st = S_LIST;
                            end
                        end
                        default: begin
                            n_status = smse_pkg::ST_MISS;
                            n_st     = S_RESP;
                        end
                    endcase
                end
            end
            S_SHDN: begin
                if (r_j + CW'(1) >= r_cnt) begin
                    n_cnt = r_cnt - CW'(1);
                    if (r_cmd == smse_pkg::CMD_MOVE) begin
                        n_ok   = (r_np < r_clip);
                        n_i    = '0;
                        n_wait = 1'b0;
                        n_st   = S_PRUNE;
                    end else begin
                        n_st = S_RESP;
                    end
                end else if (!r_wait) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_j + CW'(1));
                    n_wait  = 1'b1;
                end else begin
                    o_we    = 1'b1;
                    o_waddr = AW'(r_j);
                    o_wdata = i_rdata;
                    n_j     = r_j + CW'(1);
                    n_wait  = 1'b0;
                end
            end
            S_PRUNE: begin
                if (!r_wait && r_i == r_cnt) begin
                    n_i = '0;
                    if (r_ok) begin
                        n_st = S_ISCAN;
                    end else begin
                        n_status = (r_cmd == smse_pkg::CMD_MOVE) ? smse_pkg::ST_MISS
                                                                 : smse_pkg::ST_OK;
                        n_st = S_RESP;
                    end
                end else if (!r_wait) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_i);
                    n_wait  = 1'b1;
                end else begin
                    n_wait = 1'b0;
                    if (i_rdata >= r_clip) begin
                        n_cnt = r_i;
                    end else begin
                        n_i = r_i + CW'(1);
                    end
                end
            end
            S_ISCAN: begin
                if (!r_wait && r_i != r_cnt) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_i);
                    n_wait  = 1'b1;
                end else if (r_wait && i_rdata < r_np) begin
                    n_i    = r_i + CW'(1);
                    n_wait = 1'b0;
                end else begin
                    n_wait = 1'b0;
                    if (r_wait && i_rdata == r_np) begin
                        n_fidx = AW'(r_i);
                        n_st   = S_RESP;
                    end else if (32'(r_cnt) >= 32'(MAX_ENTRIES)) begin
                        n_status = smse_pkg::ST_FULL;
                        n_st     = S_RESP;
                    end else begin
                        n_j  = r_cnt;
                        n_st = S_SHUP;
                    end
                end
            end
            S_SHUP: begin
                if (r_j == r_i) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(r_i);
                    o_wdata = r_np;
                    n_cnt   = r_cnt + CW'(1);
                    n_fidx  = AW'(r_i);
                    n_st    = S_RESP;
                end else if (!r_wait) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_j - CW'(1));
                    n_wait  = 1'b1;
                end else begin
                    o_we    = 1'b1;
                    o_waddr = AW'(r_j);
                    o_wdata = i_rdata;
                    n_j     = r_j - CW'(1);
                    n_wait  = 1'b0;
                end
            end
            S_FIND: begin
                if (!r_wait && r_i == r_cnt) begin
                    n_status = r_fnd ? smse_pkg::ST_OK : smse_pkg::ST_MISS;
                    n_fidx   = r_fnd ? r_best : '0;
                    n_st     = S_RESP;
                end else if (!r_wait) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_i);
                    n_wait  = 1'b1;
                end else begin
                    if (gap_abs <= {2'b00, r_tol} && gap_abs < r_bestd) begin
                        n_bestd = gap_abs;
                        n_best  = AW'(r_i);
                        n_fnd   = 1'b1;
                    end
                    n_i    = r_i + CW'(1);
                    n_wait = 1'b0;
                end
            end
            S_LIST: begin
                if (!r_wait && r_i == r_cnt) begin
                    if (out_free) begin
                        n_ov       = 1'b1;
                        n_o_status = smse_pkg::ST_OK;
                        n_o_fidx   = '0;
                        n_o_rs     = r_prev;
                        n_o_re     = r_clip;
                        n_o_cnt    = smse_pkg::CNT_W'(r_cnt);
                        n_o_last   = 1'b1;
                        n_st       = S_IDLE;
                    end
                end else if (!r_wait) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_i);
                    n_wait  = 1'b1;
                end else if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = smse_pkg::ST_OK;
                    n_o_fidx   = '0;
                    n_o_rs     = r_prev;
                    n_o_re     = i_rdata;
                    n_o_cnt    = smse_pkg::CNT_W'(r_cnt);
                    n_o_last   = 1'b0;
                    n_prev     = i_rdata;
                    n_i        = r_i + CW'(1);
                    n_wait     = 1'b0;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_fidx   = (r_cmd == smse_pkg::CMD_INSERT) ? '0
                                                                 : smse_pkg::FIDX_W'(r_fidx);
                    n_o_rs     = '0;
                    n_o_re     = '0;
                    n_o_cnt    = smse_pkg::CNT_W'(r_cnt);
                    n_o_last   = 1'b1;
                    n_st       = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_cnt  <= '0;
            r_wait <= 1'b0;
            r_ov   <= 1'b0;
            r_clip <= '0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_wait <= n_wait;
            r_ov   <= n_ov;
            if (i_cfg.valid) begin
                r_clip <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_np       <= n_np;
        r_ok       <= n_ok;
        r_pos      <= n_pos;
        r_tol      <= n_tol;
        r_i        <= n_i;
        r_j        <= n_j;
        r_bestd    <= n_bestd;
        r_best     <= n_best;
        r_fnd      <= n_fnd;
        r_prev     <= n_prev;
        r_status   <= n_status;
        r_fidx     <= n_fidx;
        r_o_status <= n_o_status;
        r_o_fidx   <= n_o_fidx;
        r_o_rs     <= n_o_rs;
        r_o_re     <= n_o_re;
        r_o_cnt    <= n_o_cnt;
        r_o_last   <= n_o_last;
    end

    assign o_res.valid        = r_ov;
    assign o_res.status       = r_o_status;
    assign o_res.found_index  = r_o_fidx;
    assign o_res.region_start = r_o_rs;
    assign o_res.region_end   = r_o_re;
    assign o_res.entry_count  = r_o_cnt;
    assign o_res.last         = r_o_last;
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives marker edit commands with random idling and checks every result item
// against a behavioral model of the sorted marker set
// ----------------------------------------------------------------------------
module testbench;
    import smse_pkg::*;

    localparam int TIMEOUT_CYCLES = 20000;
    localparam int SETTLE_CYCLES  = 300;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FIDX_W-1:0] found_index;
        logic [POS_W-1:0]  region_start;
        logic [POS_W-1:0]  region_end;
        logic [CNT_W-1:0]  entry_count;
        logic              last;
    } marker_result_t;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic signed [31:0]  position;
        logic [IDX_W-1:0]    entry_index;
        logic [POS_W-1:0]    tolerance;
        logic [POS_W-1:0]    clip;
        bit                  typed;
        logic [STAT_W-1:0]   want_status;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    smse_cmd_if cmd_ch ();
    smse_res_if res_ch ();
    smse_cfg_if cfg_ch ();

    sorted_marker_set_engine_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    logic [POS_W-1:0] marker_pos [MAX_ENTRIES_DEF];
    int               marker_cnt;
    logic [POS_W-1:0] model_clip;
    marker_result_t   pending_results [$];

    int  error_count;
    int  idle_count;
    bit  rx_idle_enable;
    bit  rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic marker_result_t mk_result(logic [STAT_W-1:0] st, int fi,
                                                 logic [POS_W-1:0] rs,
                                                 logic [POS_W-1:0] re, bit lst);
        marker_result_t r;
        r.status       = st;
        r.found_index  = fi[FIDX_W-1:0];
        r.region_start = rs;
        r.region_end   = re;
        r.entry_count  = marker_cnt[CNT_W-1:0];
        r.last         = lst;
        return r;
    endfunction

    function automatic void queue_result(marker_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void drop_past_clip();
        int i;
        i = 0;
        while (i < marker_cnt && marker_pos[i] < model_clip) i++;
        marker_cnt = i;
    endfunction

    function automatic logic [STAT_W-1:0] add_marker(logic [POS_W-1:0] p);
        int i;
        i = 0;
        while (i < marker_cnt && marker_pos[i] < p) i++;
        if (i < marker_cnt && marker_pos[i] == p) return ST_OK;
        if (marker_cnt >= MAX_ENTRIES_DEF) return ST_FULL;
        for (int k = marker_cnt; k > i; k--) marker_pos[k] = marker_pos[k-1];
        marker_pos[i] = p;
        marker_cnt++;
        return ST_OK;
    endfunction

    function automatic void delete_marker(int i);
        for (int k = i; k < marker_cnt - 1; k++) marker_pos[k] = marker_pos[k+1];
        marker_cnt--;
    endfunction

    function automatic void predict_markers(logic [CMD_W-1:0] cmd, logic signed [31:0] pos,
                                            logic [IDX_W-1:0] idx, logic [POS_W-1:0] tol);
        longint p, len, hi, np, d, bestd;
        int best, i;
        bit found;
        logic [STAT_W-1:0] st;
        logic [POS_W-1:0] prev;
        p   = pos;
        len = model_clip;
        case (cmd)
            CMD_INSERT: begin
                st = ST_OK;
                drop_past_clip();
                if (p > 0 && p < len) st = add_marker(p[POS_W-1:0]);
                queue_result(mk_result(st, 0, 0, 0, 1));
            end
            CMD_REMOVE: begin
                if (idx < marker_cnt) begin
                    delete_marker(idx);
                    queue_result(mk_result(ST_OK, 0, 0, 0, 1));
                end else begin
                    queue_result(mk_result(ST_MISS, 0, 0, 0, 1));
                end
            end
            CMD_MOVE: begin
                hi = (len - 1 > 1) ? len - 1 : 1;
                np = (p < 1) ? 1 : ((p > hi) ? hi : p);
                if (idx >= marker_cnt) begin
                    queue_result(mk_result(ST_MISS, 0, 0, 0, 1));
                end else begin
                    delete_marker(idx);
                    drop_past_clip();
                    if (np >= len) begin
                        queue_result(mk_result(ST_MISS, 0, 0, 0, 1));
                    end else begin
                        void'(add_marker(np[POS_W-1:0]));
                        for (i = 0; i < marker_cnt; i++)
                            if (marker_pos[i] == np[POS_W-1:0]) break;
                        queue_result(mk_result(ST_OK, i, 0, 0, 1));
                    end
                end
            end
            CMD_FIND: begin
                found = 0;
                best  = 0;
                bestd = longint'(tol) + 1;
                for (i = 0; i < marker_cnt; i++) begin
                    d = longint'(marker_pos[i]) - p;
                    if (d < 0) d = -d;
                    if (d <= tol && d < bestd) begin
                        best  = i;
                        bestd = d;
                        found = 1;
                    end
                end
                queue_result(mk_result(found ? ST_OK : ST_MISS,
                                       found ? best : 0, 0, 0, 1));
            end
            CMD_CLEAR: begin
                marker_cnt = 0;
                queue_result(mk_result(ST_OK, 0, 0, 0, 1));
            end
            CMD_LIST: begin
                if (marker_cnt == 0) begin
                    queue_result(mk_result(ST_MISS, 0, 0, 0, 1));
                end else begin
                    prev = '0;
                    for (i = 0; i < marker_cnt; i++) begin
                        queue_result(mk_result(ST_OK, 0, prev, marker_pos[i], 0));
                        prev = marker_pos[i];
                    end
                    queue_result(mk_result(ST_OK, 0, prev, model_clip, 1));
                end
            end
            default: queue_result(mk_result(ST_MISS, 0, 0, 0, 1));
        endcase
    endfunction

    // result checker and receiver ready
    always @(posedge i_clk) begin
        marker_result_t got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.status, res_ch.found_index, res_ch.region_start,
                    res_ch.region_end, res_ch.entry_count, res_ch.last};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result item", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.found_index !== want.found_index)
                    report_mismatch("found_index", got.found_index, want.found_index);
                if (got.region_start !== want.region_start)
                    report_mismatch("region_start", got.region_start, want.region_start);
                if (got.region_end !== want.region_end)
                    report_mismatch("region_end", got.region_end, want.region_end);
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", got.entry_count, want.entry_count);
                if (got.last !== want.last)
                    report_mismatch("last", got.last, want.last);
            end
        end
    end

    initial begin
        int burst;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                res_ch.ready <= 1'b0;
            end else if (rx_idle_enable && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 13);
                res_ch.ready <= 1'b0;
                repeat (burst - 1) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on accepted items
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > TIMEOUT_CYCLES) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic write_clip(input logic [POS_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        model_clip = v;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_command(input logic [CMD_W-1:0] c, input logic signed [31:0] p,
                                input logic [IDX_W-1:0] ix, input logic [POS_W-1:0] t,
                                input bit gaps);
        if (gaps && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= c;
        cmd_ch.position    <= p;
        cmd_ch.entry_index <= ix;
        cmd_ch.tolerance   <= t;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_markers(c, p, ix, t);
    endtask

    function automatic logic signed [31:0] pick_position();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return -$signed({1'b0, 31'($urandom_range(1, 50))});
            2:       return model_clip + $urandom_range(0, 3) - 1;
            3:       return (marker_cnt > 0) ? marker_pos[$urandom_range(0, marker_cnt-1)] : 5;
            default: return $urandom_range(0, (model_clip > 2) ? model_clip : 2);
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CMD_INSERT;
        if (r < 55) return CMD_REMOVE;
        if (r < 70) return CMD_MOVE;
        if (r < 85) return CMD_FIND;
        if (r < 88) return CMD_CLEAR;
        if (r < 97) return CMD_LIST;
        return CMD_W'($urandom_range(6, 7));
    endfunction

    stim_row_t directed_rows [] = '{
        '{CMD_LIST,   0, 0, 0, 1000, 1, ST_MISS},
        '{CMD_FIND,   5, 0, 100, 1000, 1, ST_MISS},
        '{CMD_REMOVE, 0, 0, 0, 1000, 1, ST_MISS},
        '{CMD_MOVE,   0, 255, 0, 1000, 1, ST_MISS},
        '{CMD_INSERT, 500, 0, 0, 1000, 0, ST_OK},
        '{CMD_INSERT, 500, 0, 0, 1000, 0, ST_OK},
        '{CMD_INSERT, 0, 0, 0, 1000, 0, ST_OK},
        '{CMD_INSERT, 1000, 0, 0, 1000, 0, ST_OK},
        '{CMD_INSERT, 32'sh8000_0000, 0, 0, 1000, 0, ST_OK},
        '{CMD_INSERT, 1, 0, 0, 1000, 0, ST_OK},
        '{CMD_INSERT, 999, 0, 0, 1000, 0, ST_OK},
        '{CMD_FIND,   32'sh7fff_ffff, 0, 31'h7fff_ffff, 1000, 0, ST_OK},
        '{CMD_FIND,   750, 0, 249, 1000, 0, ST_OK},
        '{CMD_FIND,   750, 0, 248, 1000, 0, ST_OK},
        '{CMD_MOVE,   -7, 2, 0, 1000, 0, ST_OK},
        '{CMD_MOVE,   32'sh7fff_ffff, 0, 0, 1000, 0, ST_OK},
        '{CMD_LIST,   0, 0, 0, 1000, 0, ST_OK},
        '{CMD_REMOVE, 0, 200, 0, 1000, 1, ST_MISS},
        '{CMD_REMOVE, 0, 0, 0, 1000, 0, ST_OK},
        '{CMD_INSERT, 5, 0, 0, 1000, 0, ST_OK},
        '{CMD_LIST,   0, 0, 0, 600, 0, ST_OK},
        '{CMD_INSERT, 7, 0, 0, 600, 0, ST_OK},
        '{CMD_MOVE,   5, 0, 0, 1, 0, ST_OK},
        '{CMD_CLEAR,  0, 0, 0, 1, 1, ST_OK},
        '{3'd6,       0, 0, 0, 1, 1, ST_MISS},
        '{3'd7,       -1, 8'hff, 31'h7fff_ffff, 1, 1, ST_MISS}
    };

    initial begin
        logic [POS_W-1:0] clip_choices [] = '{0, 1, 2, 40, 300, 31'h7fff_ffff, 100000};
        int n;
        error_count    = 0;
        marker_cnt     = 0;
        model_clip     = '0;
        rx_idle_enable = 1'b1;
        rx_hold        = 1'b0;
        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.cmd         = CMD_INSERT;
        cmd_ch.position    = '0;
        cmd_ch.entry_index = '0;
        cmd_ch.tolerance   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].clip != model_clip) begin
                cmd_ch.valid <= 1'b0;
                drain_results();
                write_clip(directed_rows[r].clip);
            end
            send_command(directed_rows[r].cmd, directed_rows[r].position,
                         directed_rows[r].entry_index, directed_rows[r].tolerance, 1);
            if (directed_rows[r].typed &&
                pending_results[pending_results.size()-1].status !== directed_rows[r].want_status)
                report_mismatch("directed status", pending_results[$].status,
                                directed_rows[r].want_status);
        end

        for (int ph = 0; ph < 7; ph++) begin
            cmd_ch.valid <= 1'b0;
            drain_results();
            write_clip(ph == 6 ? 31'($urandom_range(3, 5000)) : clip_choices[ph]);
            if (ph == 6) rx_idle_enable = 1'b0;
            n = (ph == 5) ? 40 : 45;
            for (int k = 0; k < n; k++) begin
                if (ph == 3 && k == 10) begin
                    fork
                        begin
                            rx_hold = 1'b1;
                            repeat (600) @(posedge i_clk);
                            rx_hold = 1'b0;
                        end
                    join_none
                end
                if (ph == 4 && k == 20) begin
                    cmd_ch.valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
                send_command(pick_command(), pick_position(), $urandom_range(0, 40) == 0 ?
                             8'($urandom) : 8'($urandom_range(0, marker_cnt + 1)),
                             $urandom_range(0, 3) == 0 ? 31'($urandom) :
                             31'($urandom_range(0, 200)), ph != 6);
            end
        end
        cmd_ch.valid <= 1'b0;
        drain_results();
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
